/* src/brm_pkg.sv */
// Package for the byte register machine execute core.
// Holds widths, opcode codes and the structs shared by the channels and modules.
// No dependencies.
package brm_pkg;

	localparam int REG_COUNT = 16;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int DATA_W    = 8;

	typedef logic [DATA_W-1:0] brm_byte_t;
	typedef logic [REG_AW-1:0] brm_raddr_t;

	// Opcode codes; anything else is a no-op
	typedef enum logic [7:0] {
		OP_INC  = 8'h01,
		OP_DEC  = 8'h02,
		OP_MOV  = 8'h03,
		OP_MOVC = 8'h04,
		OP_LSL  = 8'h05,
		OP_LSR  = 8'h06,
		OP_JMP  = 8'h07,
		OP_JFE  = 8'h0A,
		OP_RET  = 8'h0B,
		OP_ADD  = 8'h0C,
		OP_SUB  = 8'h0D,
		OP_XOR  = 8'h0E,
		OP_OR   = 8'h0F,
		OP_IN   = 8'h10,
		OP_OUT  = 8'h11
	} brm_op_t;

	// One instruction plus the input stream sample
	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] operand;
		logic [7:0] in_byte;
		logic       in_end;
	} brm_item_t;

	// One execution result
	typedef struct packed {
		logic [7:0] next_pc;
		logic       out_valid;
		logic [7:0] out_byte;
		logic       byte_taken;
		logic       halted;
	} brm_result_t;

	// Architectural state outside the register file
	typedef struct packed {
		logic [7:0] pc;
		logic       end_flag;
		logic       halt;
	} brm_arch_t;

	// Register file write request
	typedef struct packed {
		logic       we;
		brm_raddr_t addr;
		brm_byte_t  data;
	} brm_rf_wr_t;

endpackage

/* src/brm_item_if.sv */
// Instruction channel: valid/ready handshake carrying one instruction item.
// Depends on brm_pkg.
interface brm_item_if;
	import brm_pkg::*;

	logic      valid;
	logic      ready;
	brm_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* src/brm_result_if.sv */
// Result channel: valid/ready handshake carrying one execution result.
// Depends on brm_pkg.
interface brm_result_if;
	import brm_pkg::*;

	logic        valid;
	logic        ready;
	brm_result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* src/byte_register_machine_execute_core.sv */
// Byte register machine execute core: one instruction per transfer, one result each.
// Registers: input stage, then result register. Throughput: one instruction per cycle
// unless the result side stalls; the register file read is registered at accept time
// and bypassed from the write of the instruction executing in that same cycle.
// Reset (arst_n, async): pc, end flag and halt mark clear, all registers read as zero.
// Depends on brm_pkg, brm_item_if, brm_result_if, brm_regfile, brm_exec.
module byte_register_machine_execute_core (
	input  logic   clk,
	input  logic   arst_n,
	brm_item_if.sink     item,
	brm_result_if.source result
);
	import brm_pkg::*;

	logic        vld_s1;
	brm_item_t   item_s1;
	logic        out_vld_q;
	brm_result_t out_q;
	brm_arch_t   arch_q;

	logic        take_in;
	logic        exec_fire;
	brm_byte_t   rd_val;
	brm_byte_t   rs_val;
	brm_rf_wr_t  rf_wr_raw;
	brm_rf_wr_t  rf_wr;
	brm_arch_t   arch_nxt;
	brm_result_t res;

	// Handshake: execute when the result register is free or draining
	assign exec_fire  = vld_s1 && (!out_vld_q || result.ready);
	assign item.ready = !vld_s1 || exec_fire;
	assign take_in    = item.valid && item.ready;

	// Register file, read at transfer time
	brm_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (take_in),
		.rd_addr_a (item.payload.operand[REG_AW-1:0]),
		.rd_addr_b (item.payload.operand[2*REG_AW-1:REG_AW]),
		.wr        (rf_wr),
		.rd_data_a (rd_val),
		.rd_data_b (rs_val)
	);

	// Execute stage
	brm_exec u_exec (
		.item     (item_s1),
		.arch     (arch_q),
		.rd_val   (rd_val),
		.rs_val   (rs_val),
		.rf_wr    (rf_wr_raw),
		.arch_nxt (arch_nxt),
		.res      (res)
	);

	assign rf_wr = '{we: rf_wr_raw.we && exec_fire, addr: rf_wr_raw.addr, data: rf_wr_raw.data};

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			arch_q    <= '0;
		end else begin
			if (take_in) begin
				vld_s1 <= 1'b1;
			end else if (exec_fire) begin
				vld_s1 <= 1'b0;
			end
			if (exec_fire) begin
				out_vld_q <= 1'b1;
				arch_q    <= arch_nxt;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item.payload;
		end
		if (exec_fire) begin
			out_q <= res;
		end
	end

	assign result.valid   = out_vld_q;
	assign result.payload = out_q;

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		arch_q.halt |=> arch_q.halt)
		else $error("halt mark cleared after being set");

	a_halt_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arch_q.halt |=> $stable(arch_q.pc))
		else $error("pc moved while halted");

	a_wr_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr.we |-> (exec_fire && !arch_q.halt))
		else $error("register write outside an executing instruction");

	a_halt_result: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && res.halted) |=> (arch_q.halt && out_vld_q && out_q.halted))
		else $error("halted result without halt state");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (vld_s1 && out_vld_q && !result.ready))
		else $error("input stalled without a full pipeline");
`endif

endmodule

/* src/brm_regfile.sv */
// Sixteen-entry byte register file: one write port, two registered read ports.
// Entries never written read as zero via per-entry valid bits. Depends on brm_pkg.
module brm_regfile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  brm_pkg::brm_raddr_t rd_addr_a,
	input  brm_pkg::brm_raddr_t rd_addr_b,
	input  brm_pkg::brm_rf_wr_t wr,
	output brm_pkg::brm_byte_t  rd_data_a,
	output brm_pkg::brm_byte_t  rd_data_b
);
	import brm_pkg::*;

	brm_byte_t              mem [REG_COUNT];
	logic [REG_COUNT-1:0]   filled_q;
	brm_byte_t              rd_data_a_q;
	brm_byte_t              rd_data_b_q;

	// Storage array
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Written marks, cleared at reset so the file reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (wr.we) begin
			filled_q[wr.addr] <= 1'b1;
		end
	end

	// Registered reads with write-through of a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.we && (wr.addr == rd_addr_a)) begin
				rd_data_a_q <= wr.data;
			end else if (filled_q[rd_addr_a]) begin
				rd_data_a_q <= mem[rd_addr_a];
			end else begin
				rd_data_a_q <= '0;
			end
			if (wr.we && (wr.addr == rd_addr_b)) begin
				rd_data_b_q <= wr.data;
			end else if (filled_q[rd_addr_b]) begin
				rd_data_b_q <= mem[rd_addr_b];
			end else begin
				rd_data_b_q <= '0;
			end
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

/* src/brm_exec.sv */
// Execute logic: decodes one instruction and computes the register write,
// the next architectural state and the result. Depends on brm_pkg.
module brm_exec (
	input  brm_pkg::brm_item_t   item,
	input  brm_pkg::brm_arch_t   arch,
	input  brm_pkg::brm_byte_t   rd_val,
	input  brm_pkg::brm_byte_t   rs_val,
	output brm_pkg::brm_rf_wr_t  rf_wr,
	output brm_pkg::brm_arch_t   arch_nxt,
	output brm_pkg::brm_result_t res
);
	import brm_pkg::*;

	brm_raddr_t dst;
	logic [7:0] pc_inc;
	logic [7:0] pc_jmp;

	assign dst    = item.operand[REG_AW-1:0];
	assign pc_inc = arch.pc + 8'd2;
	assign pc_jmp = arch.pc + item.operand;

	// Decode and execute
	always_comb begin
		rf_wr          = '{we: 1'b0, addr: dst, data: rd_val};
		arch_nxt       = arch;
		arch_nxt.pc    = pc_inc;
		res            = '0;
		if (arch.halt) begin
			// halted: hold everything, report the held pc
			arch_nxt    = arch;
			res.next_pc = arch.pc;
			res.halted  = 1'b1;
		end else begin
			unique case (item.kind)
				OP_INC: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val + 8'd1;
				end
				OP_DEC: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val - 8'd1;
				end
				OP_MOV: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rs_val;
				end
				OP_MOVC: begin
					rf_wr.we   = 1'b1;
					rf_wr.addr = '0;
					rf_wr.data = item.operand;
				end
				OP_LSL: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = {rd_val[DATA_W-2:0], 1'b0};
				end
				OP_LSR: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = {1'b0, rd_val[DATA_W-1:1]};
				end
				OP_JMP: begin
					arch_nxt.pc = pc_jmp;
				end
				OP_JFE: begin
					if (arch.end_flag) begin
						arch_nxt.pc = pc_jmp;
					end
				end
				OP_RET: begin
					arch_nxt.halt = 1'b1;
				end
				OP_ADD: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val + rs_val;
				end
				OP_SUB: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val - rs_val;
				end
				OP_XOR: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val ^ rs_val;
				end
				OP_OR: begin
					rf_wr.we   = 1'b1;
					rf_wr.data = rd_val | rs_val;
				end
				OP_IN: begin
					if (item.in_end) begin
						arch_nxt.end_flag = 1'b1;
					end else begin
						rf_wr.we          = 1'b1;
						rf_wr.data        = item.in_byte;
						arch_nxt.end_flag = 1'b0;
						res.byte_taken    = 1'b1;
					end
				end
				OP_OUT: begin
					if (!arch.end_flag) begin
						res.out_valid = 1'b1;
						res.out_byte  = rd_val;
					end
				end
				default: begin
				end
			endcase
			res.next_pc = arch_nxt.pc;
			res.halted  = arch_nxt.halt;
		end
	end

endmodule

/* sim/tb_byte_register_machine_execute_core.sv */
// Testbench for byte_register_machine_execute_core: a directed table and random
// instructions, each result checked against a built-in model of the machine or the table's expectation.
// Depends on brm_pkg, brm_item_if, brm_result_if and the core itself.
module tb_byte_register_machine_execute_core;
	import brm_pkg::*;

	// One line of the directed table; exp is used only when typed is set
	typedef struct {
		brm_item_t   it;
		bit          typed;
		brm_result_t exp;
	} plan_row_t;

	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AT      = 200;
	localparam int RAND_ITEMS   = 1000;
	localparam int MAX_REPORTS  = 20;

	// Bytes outside the opcode map; the machine treats them as no-ops
	localparam logic [7:0] NOP_ZERO = 8'h00;
	localparam logic [7:0] NOP_ONES = 8'hFF;

	logic clk;
	logic arst_n;

	brm_item_if   item_ch();
	brm_result_if result_ch();

	byte_register_machine_execute_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Machine state as the model sees it
	logic [7:0] mach_regs [REG_COUNT];
	logic [7:0] mach_pc;
	logic       mach_end;
	logic       mach_halt;

	brm_result_t pending_results [$];
	int          err_count;
	int          done_count;
	bit          quiet;

	// Executes one instruction on the model state and returns its result
	function automatic brm_result_t machine_step(input brm_item_t it);
		brm_result_t r;
		brm_raddr_t  d;
		brm_raddr_t  s;
		logic [7:0]  npc;
		d   = it.operand[3:0];
		s   = it.operand[7:4];
		npc = mach_pc + 8'd2;
		r   = '0;
		if (mach_halt) begin
			r.next_pc = mach_pc;
			r.halted  = 1'b1;
			return r;
		end
		case (it.kind)
			OP_INC:  mach_regs[d] = mach_regs[d] + 8'd1;
			OP_DEC:  mach_regs[d] = mach_regs[d] - 8'd1;
			OP_MOV:  mach_regs[d] = mach_regs[s];
			OP_MOVC: mach_regs[0] = it.operand;
			OP_LSL:  mach_regs[d] = {mach_regs[d][6:0], 1'b0};
			OP_LSR:  mach_regs[d] = {1'b0, mach_regs[d][7:1]};
			OP_JMP:  npc = mach_pc + it.operand;
			OP_JFE: begin
				if (mach_end)
					npc = mach_pc + it.operand;
			end
			OP_RET:  mach_halt = 1'b1;
			OP_ADD:  mach_regs[d] = mach_regs[d] + mach_regs[s];
			OP_SUB:  mach_regs[d] = mach_regs[d] - mach_regs[s];
			OP_XOR:  mach_regs[d] = mach_regs[d] ^ mach_regs[s];
			OP_OR:   mach_regs[d] = mach_regs[d] | mach_regs[s];
			OP_IN: begin
				if (it.in_end) begin
					mach_end = 1'b1;
				end else begin
					mach_regs[d] = it.in_byte;
					mach_end     = 1'b0;
					r.byte_taken = 1'b1;
				end
			end
			OP_OUT: begin
				if (!mach_end) begin
					r.out_valid = 1'b1;
					r.out_byte  = mach_regs[d];
				end
			end
			default: ;
		endcase
		mach_pc   = npc;
		r.next_pc = npc;
		r.halted  = mach_halt;
		return r;
	endfunction

	function automatic plan_row_t mk_row(input logic [7:0] kind, input logic [7:0] operand,
			input logic [7:0] in_byte, input logic in_end, input bit typed,
			input logic [7:0] pc, input logic ov, input logic [7:0] ob, input logic tk);
		plan_row_t row;
		row.it    = '{kind: kind, operand: operand, in_byte: in_byte, in_end: in_end};
		row.typed = typed;
		row.exp   = '{next_pc: pc, out_valid: ov, out_byte: ob, byte_taken: tk, halted: 1'b0};
		return row;
	endfunction

	// Random instruction: mostly real opcodes, some raw bytes; never a halt
	function automatic brm_item_t rand_item();
		brm_op_t   ops [14] = '{OP_INC, OP_DEC, OP_MOV, OP_MOVC, OP_LSL, OP_LSR, OP_JMP,
			OP_JFE, OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_IN, OP_OUT};
		brm_item_t it;
		if ($urandom_range(99) < 88)
			it.kind = ops[$urandom_range(13)];
		else
			it.kind = 8'($urandom_range(255));
		if (it.kind == OP_RET)
			it.kind = OP_OUT;
		it.operand = 8'($urandom_range(255));
		it.in_byte = 8'($urandom_range(255));
		it.in_end  = ($urandom_range(4) == 0);
		return it;
	endfunction

	// Offers one item until it transfers, then records what it should produce
	task automatic issue(input brm_item_t it, input bit typed, input brm_result_t given);
		brm_result_t pred;
		while (!quiet && $urandom_range(99) < 7) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		pred = machine_step(it);
		pending_results.push_back(typed ? given : pred);
	endtask

	task automatic flag(input string field, input logic [7:0] exp, input logic [7:0] act);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
	endtask

	// Compares one transferred result with the oldest expectation
	task automatic check_result(input brm_result_t act);
		brm_result_t exp;
		if (pending_results.size() == 0) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: unexpected result, expected none, actual %h", $time, act);
			return;
		end
		exp = pending_results.pop_front();
		if (act.next_pc !== exp.next_pc)
			flag("next_pc", exp.next_pc, act.next_pc);
		if (act.out_valid !== exp.out_valid)
			flag("out_valid", 8'(exp.out_valid), 8'(act.out_valid));
		if (act.out_byte !== exp.out_byte)
			flag("out_byte", exp.out_byte, act.out_byte);
		if (act.byte_taken !== exp.byte_taken)
			flag("byte_taken", 8'(exp.byte_taken), 8'(act.byte_taken));
		if (act.halted !== exp.halted)
			flag("halted", 8'(exp.halted), 8'(act.halted));
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#3000000;
		$display("tb_byte_register_machine_execute_core: done, errors");
		$finish;
	end

	// Result side: check transfers, random stalls, one long hold-off
	initial begin
		int  hold;
		bit  hold_done;
		hold      = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				check_result(result_ch.payload);
				done_count++;
			end
			if (!hold_done && done_count >= HOLD_AT) begin
				hold      = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= quiet || ($urandom_range(99) >= 7);
			end
		end
	end

	// Stimulus and end of run
	initial begin
		plan_row_t   plan [$];
		brm_result_t none;
		brm_item_t   it;
		none       = '0;
		err_count  = 0;
		done_count = 0;
		quiet      = 1'b0;
		mach_pc    = '0;
		mach_end   = 1'b0;
		mach_halt  = 1'b0;
		foreach (mach_regs[i])
			mach_regs[i] = '0;

		arst_n          = 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.payload <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, wraps, every opcode but RET, end-flag cases, jumps, no-ops
		plan = '{
			mk_row(OP_OUT,  8'h00, 8'h00, 1'b0, 1, 8'd2,  1'b1, 8'h00, 1'b0),
			mk_row(OP_MOVC, 8'hFF, 8'h00, 1'b0, 1, 8'd4,  1'b0, 8'h00, 1'b0),
			mk_row(OP_OUT,  8'h00, 8'h00, 1'b0, 1, 8'd6,  1'b1, 8'hFF, 1'b0),
			mk_row(OP_INC,  8'h00, 8'h00, 1'b0, 1, 8'd8,  1'b0, 8'h00, 1'b0),
			mk_row(OP_DEC,  8'h01, 8'h00, 1'b0, 1, 8'd10, 1'b0, 8'h00, 1'b0),
			mk_row(OP_OUT,  8'h01, 8'h00, 1'b0, 1, 8'd12, 1'b1, 8'hFF, 1'b0),
			mk_row(OP_MOV,  8'h1F, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_LSL,  8'h0F, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_LSR,  8'h0F, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_OUT,  8'h0F, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_IN,   8'h03, 8'hA5, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_IN,   8'h04, 8'hFF, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_ADD,  8'h34, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_SUB,  8'h43, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_XOR,  8'h13, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_OR,   8'h45, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_OUT,  8'h05, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_JFE,  8'h10, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_JMP,  8'h00, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_JMP,  8'h80, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_IN,   8'h06, 8'h5A, 1'b1, 0, 0, 0, 0, 0),
			mk_row(OP_OUT,  8'h00, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(OP_JFE,  8'hF0, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(NOP_ZERO, 8'h00, 8'h00, 1'b0, 0, 0, 0, 0, 0),
			mk_row(NOP_ONES, 8'hFF, 8'hFF, 1'b1, 0, 0, 0, 0, 0),
			mk_row(OP_IN,   8'h0A, 8'h3C, 1'b0, 0, 0, 0, 0, 0)
		};
		foreach (plan[i])
			issue(plan[i].it, plan[i].typed, plan[i].exp);

		// Random program; a stretch in the middle runs without any idling
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet = (i >= 400 && i < 600);
			issue(rand_item(), 1'b0, none);
		end
		quiet = 1'b0;

		// Halt last, then a few items that must be ignored
		it      = rand_item();
		it.kind = OP_RET;
		issue(it, 1'b0, none);
		repeat (4)
			issue(rand_item(), 1'b0, none);
		item_ch.valid <= 1'b0;

		// Drain
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("tb_byte_register_machine_execute_core: done, clean");
		else
			$display("tb_byte_register_machine_execute_core: done, errors");
		$finish;
	end

endmodule

/* sim.f */
src/brm_pkg.sv
src/brm_item_if.sv
src/brm_result_if.sv
src/brm_regfile.sv
src/brm_exec.sv
src/byte_register_machine_execute_core.sv
sim/tb_byte_register_machine_execute_core.sv
